### rtl/core/sphere_vertex_generator_unit_defines.svh
// Assertion macros used by the sphere vertex generator checker.
// Needs nothing else; include by bare file name.
`ifndef SPHERE_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define SPHERE_VERTEX_GENERATOR_UNIT_DEFINES_SVH

// implication checked while reset is low
`define SVG_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svg check failed");

// next-cycle implication, reset included
`define SVG_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("svg check failed");

`endif

### rtl/core/svg_pkg.sv
// Shared constants, types and rounding helpers of the sphere vertex generator.
// No dependencies.
package svg_pkg;

   localparam int MaxSlices  = 64;
   localparam int MaxStacks  = 64;
   localparam int NumStages  = 14;

   localparam logic [23:0] QuarterPhase = 24'h40_0000;

   localparam logic [31:0] CoefC1 = 32'd1686629713;
   localparam logic [31:0] CoefC3 = 32'd693598668;
   localparam logic [31:0] CoefC5 = 32'd85569306;
   localparam logic [31:0] CoefC7 = 32'd5026995;
   localparam logic [31:0] CoefC9 = 32'd172272;

   typedef enum logic [1:0] {
      CSR_SLICE_COUNT = 2'd0,
      CSR_STACK_COUNT = 2'd1,
      CSR_HEMISPHERE  = 2'd2,
      CSR_RADIUS      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        oor;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
   } side_type;

   // Q1.14 times Q1.14, round half away from zero
   function automatic logic signed [15:0] mul_norm(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
      logic [15:0] ma;
      logic [15:0] mb;
      logic [31:0] p;
      logic [15:0] m;
      ma = a[15] ? 16'(-a) : 16'(a);
      mb = b[15] ? 16'(-b) : 16'(b);
      p  = ma * mb + 32'd8192;
      m  = p[29:14];
      return (a[15] != b[15]) ? 16'(-m) : 16'(m);
   endfunction

   // Q1.14 normal times unsigned Q8.8 radius, same rounding
   function automatic logic signed [16:0] mul_rad(input logic signed [15:0] n,
                                                  input logic [15:0] r);
      logic [15:0] mn;
      logic [31:0] p;
      logic [16:0] m;
      mn = n[15] ? 16'(-n) : 16'(n);
      p  = mn * r + 32'd8192;
      m  = p[30:14];
      return n[15] ? 17'(-m) : 17'(m);
   endfunction

endpackage

### rtl/core/svg_div.sv
// Three-stage constant-reciprocal divider: round(num*2^24/den) and round(num*2^16/den).
// No dependencies; tables are built at elaboration.
module svg_div (
   input  logic        clock,
   input  logic [2:0]  en,
   input  logic [6:0]  num,
   input  logic [7:0]  den,
   output logic [23:0] q24,
   output logic [16:0] q16
);

   logic [23:0] tq24 [256];
   logic [7:0]  tr24 [256];
   logic [15:0] tq16 [256];
   logic [7:0]  tr16 [256];
   logic [22:0] tm   [256];
   logic [6:0]  th   [256];

   for (genvar d = 0; d < 256; d++) begin : g_tbl
      localparam int DD  = (d < 2) ? 2 : d;
      localparam int Q24 = (1 << 24) / DD;
      localparam int R24 = (1 << 24) % DD;
      localparam int Q16 = (1 << 16) / DD;
      localparam int R16 = (1 << 16) % DD;
      localparam int MR  = ((1 << 23) + DD - 1) / DD;
      localparam int HF  = DD / 2;
      assign tq24[d] = 24'(Q24);
      assign tr24[d] = 8'(R24);
      assign tq16[d] = 16'(Q16);
      assign tr16[d] = 8'(R16);
      assign tm[d]   = 23'(MR);
      assign th[d]   = 7'(HF);
   end

   logic [6:0]  num_ff;
   logic [23:0] q24c_ff;
   logic [7:0]  r24c_ff;
   logic [15:0] q16c_ff;
   logic [7:0]  r16c_ff;
   logic [22:0] m_ff;
   logic [6:0]  h_ff;

   logic [30:0] hi24_ff;
   logic [14:0] sm24_ff;
   logic [22:0] hi16_ff;
   logic [14:0] sm16_ff;
   logic [22:0] m2_ff;

   logic [37:0] f24;
   logic [37:0] f16;
   logic [30:0] s24_in;
   logic [22:0] s16_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         num_ff  <= num;
         q24c_ff <= tq24[den];
         r24c_ff <= tr24[den];
         q16c_ff <= tq16[den];
         r16c_ff <= tr16[den];
         m_ff    <= tm[den];
         h_ff    <= th[den];
      end
      if (en[1]) begin
         hi24_ff <= 31'(num_ff) * 31'(q24c_ff);
         sm24_ff <= 15'(num_ff) * 15'(r24c_ff) + 15'(h_ff);
         hi16_ff <= 23'(num_ff) * 23'(q16c_ff);
         sm16_ff <= 15'(num_ff) * 15'(r16c_ff) + 15'(h_ff);
         m2_ff   <= m_ff;
      end
      if (en[2]) begin
         q24 <= s24_in[23:0];
         q16 <= s16_in[16:0];
      end
   end

   always_comb begin
      f24    = 38'(sm24_ff) * 38'(m2_ff);
      f16    = 38'(sm16_ff) * 38'(m2_ff);
      s24_in = hi24_ff + 31'(f24[37:23]);
      s16_in = hi16_ff + 23'(f16[37:23]);
   end

endmodule

### rtl/core/svg_sine.sv
// Eight-stage polynomial sine of a Q0.24 phase, Q1.14 result.
// Depends on svg_pkg for the coefficients.
module svg_sine (
   input  logic               clock,
   input  logic [7:0]         en,
   input  logic [23:0]        phase,
   output logic signed [15:0] sine
);

   logic [1:0]  q_ff  [7];
   logic [30:0] x_ff  [6];
   logic [31:0] x2_ff [1:4];
   logic [31:0] s_ff  [2:6];

   logic [22:0] fold;
   logic [61:0] sq;
   logic [63:0] t2, t3, t4, t5, t6;
   logic [32:0] rnd;
   logic [16:0] mag;

   always_comb begin
      fold = phase[22] ? (23'h40_0000 - 23'(phase[21:0])) : 23'(phase[21:0]);
      sq   = x_ff[0] * x_ff[0];
      t2   = svg_pkg::CoefC9 * x2_ff[1];
      t3   = s_ff[2] * x2_ff[2];
      t4   = s_ff[3] * x2_ff[3];
      t5   = s_ff[4] * x2_ff[4];
      t6   = s_ff[5] * x_ff[5];
      rnd  = 33'(s_ff[6]) + 33'h8000;
      mag  = rnd[32:16];
      if (mag > 17'd16384) begin
         mag = 17'd16384;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         q_ff[0] <= phase[23:22];
         x_ff[0] <= {fold, 8'b0};
      end
      if (en[1]) begin
         q_ff[1]  <= q_ff[0];
         x_ff[1]  <= x_ff[0];
         x2_ff[1] <= sq[61:30];
      end
      if (en[2]) begin
         q_ff[2]  <= q_ff[1];
         x_ff[2]  <= x_ff[1];
         x2_ff[2] <= x2_ff[1];
         s_ff[2]  <= svg_pkg::CoefC7 - t2[61:30];
      end
      if (en[3]) begin
         q_ff[3]  <= q_ff[2];
         x_ff[3]  <= x_ff[2];
         x2_ff[3] <= x2_ff[2];
         s_ff[3]  <= svg_pkg::CoefC5 - t3[61:30];
      end
      if (en[4]) begin
         q_ff[4]  <= q_ff[3];
         x_ff[4]  <= x_ff[3];
         x2_ff[4] <= x2_ff[3];
         s_ff[4]  <= svg_pkg::CoefC3 - t4[61:30];
      end
      if (en[5]) begin
         q_ff[5]  <= q_ff[4];
         x_ff[5]  <= x_ff[4];
         s_ff[5]  <= svg_pkg::CoefC1 - t5[61:30];
      end
      if (en[6]) begin
         q_ff[6]  <= q_ff[5];
         s_ff[6]  <= t6[61:30];
      end
      if (en[7]) begin
         // second half turn is negative
         sine <= q_ff[6][1] ? 16'(-mag) : 16'(mag);
      end
   end

endmodule

### rtl/core/sphere_vertex_generator_unit.sv
// UV sphere vertex generator: grid (column, row) in, normal, position, texture out.
// One vertex per cycle sustained while rsp_tready is high.
// Fourteen stages: input, three divider stages, eight sine stages, normal and
// position multiplies. Each stage holds its item until the next one frees up.
// Synchronous active-high reset clears valid bits and restores the configuration registers.
module sphere_vertex_generator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // grid_column[6:0], grid_row[13:7]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // position_x/y/z, normal_x/y/z, tex_u, tex_v
   output logic         rsp_tuser,   // out_of_range
   input  logic         csr_wen,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int NS = svg_pkg::NumStages;

   logic [6:0]  slice_count_ff;
   logic [6:0]  stack_count_ff;
   logic        hemi_ff;
   logic [15:0] radius_ff;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   en;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_count_ff <= 7'd16;
         stack_count_ff <= 7'd16;
         hemi_ff        <= 1'b0;
         radius_ff      <= 16'd256;
      end else if (csr_wen) begin
         case (svg_pkg::csr_index_type'(csr_addr))
            svg_pkg::CSR_SLICE_COUNT: slice_count_ff <= csr_wdata[6:0];
            svg_pkg::CSR_STACK_COUNT: stack_count_ff <= csr_wdata[6:0];
            svg_pkg::CSR_HEMISPHERE:  hemi_ff        <= csr_wdata[0];
            svg_pkg::CSR_RADIUS:      radius_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage advances when empty or when its successor advances
   always_comb begin
      en[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NS-1];

   // input stage
   logic [7:0] slices, stacks, den;
   logic [6:0] col_in, row_in;
   logic [6:0] col_ff, row_ff;
   logic [7:0] slc_ff, stk_ff, den_ff;
   logic       oor_ff [4];

   always_comb begin
      col_in = req_tdata[6:0];
      row_in = req_tdata[13:7];
      slices = (slice_count_ff < 7'd2) ? 8'd2 :
               (slice_count_ff > 7'(svg_pkg::MaxSlices)) ? 8'(svg_pkg::MaxSlices) :
               8'(slice_count_ff);
      stacks = (stack_count_ff < 7'd2) ? 8'd2 :
               (stack_count_ff > 7'(svg_pkg::MaxStacks)) ? 8'(svg_pkg::MaxStacks) :
               8'(stack_count_ff);
      den    = hemi_ff ? 8'({stacks - 8'd1, 2'b00}) : 8'({stacks, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         slc_ff    <= slices;
         stk_ff    <= stacks;
         den_ff    <= den;
         oor_ff[0] <= (8'(col_in) > slices) || (8'(row_in) > stacks);
      end
      for (int k = 1; k < 4; k++) begin
         if (en[k]) begin
            oor_ff[k] <= oor_ff[k-1];
         end
      end
   end

   logic [23:0] pa, pp;
   logic [16:0] tex_u_q, tex_v_q;

   svg_div u_div_col (
      .clock(clock), .en(en[3:1]), .num(col_ff), .den(slc_ff),
      .q24(pa), .q16(tex_u_q)
   );

   svg_div u_div_row (
      .clock(clock), .en(en[3:1]), .num(row_ff), .den(den_ff),
      .q24(pp), .q16()
   );

   svg_div u_div_tex (
      .clock(clock), .en(en[3:1]), .num(row_ff), .den(stk_ff),
      .q24(), .q16(tex_v_q)
   );

   logic signed [15:0] sa, ca, sp, cp;

   svg_sine u_sin_a (
      .clock(clock), .en(en[11:4]), .phase(pa), .sine(sa)
   );

   svg_sine u_cos_a (
      .clock(clock), .en(en[11:4]), .phase(pa + svg_pkg::QuarterPhase), .sine(ca)
   );

   svg_sine u_sin_p (
      .clock(clock), .en(en[11:4]), .phase(pp), .sine(sp)
   );

   svg_sine u_cos_p (
      .clock(clock), .en(en[11:4]), .phase(pp + svg_pkg::QuarterPhase), .sine(cp)
   );

   // sideband travels beside the sine pipeline
   svg_pkg::side_type side_ff [4:12];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         side_ff[4] <= '{oor: oor_ff[3], tex_u: tex_u_q, tex_v: tex_v_q};
      end
      for (int k = 5; k <= 12; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [16:0] px_o, py_o, pz_o;
   logic signed [15:0] nx_o, ny_o, nz_o;
   logic [16:0]        tu_o, tv_o;
   logic               oor_o;

   always_ff @(posedge clock) begin
      if (en[12]) begin
         nx_ff <= svg_pkg::mul_norm(sp, ca);
         ny_ff <= cp;
         nz_ff <= svg_pkg::mul_norm(sp, sa);
      end
      if (en[13]) begin
         oor_o <= side_ff[12].oor;
         if (side_ff[12].oor) begin
            px_o <= '0;
            py_o <= '0;
            pz_o <= '0;
            nx_o <= '0;
            ny_o <= '0;
            nz_o <= '0;
            tu_o <= '0;
            tv_o <= '0;
         end else begin
            px_o <= svg_pkg::mul_rad(nx_ff, radius_ff);
            py_o <= svg_pkg::mul_rad(ny_ff, radius_ff);
            pz_o <= svg_pkg::mul_rad(nz_ff, radius_ff);
            nx_o <= nx_ff;
            ny_o <= ny_ff;
            nz_o <= nz_ff;
            tu_o <= side_ff[12].tex_u;
            tv_o <= side_ff[12].tex_v;
         end
      end
   end

   assign rsp_tdata = {3'b000, tv_o, tu_o, nz_o, ny_o, nx_o, pz_o, py_o, px_o};
   assign rsp_tuser = oor_o;

endmodule

### rtl/core/svg_checker.sv
// Port-level checks of the sphere vertex generator, bound to the top level.
// Depends on sphere_vertex_generator_unit_defines.svh.
`include "sphere_vertex_generator_unit_defines.svh"

module svg_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tuser
);

   `SVG_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, ##1 (rsp_tvalid && $stable(rsp_tdata)))
   `SVG_ASSERT(a_oor_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `SVG_ASSERT(a_tex_max, clock, reset, rsp_tvalid, (rsp_tdata[115:99] <= 17'h10000) && (rsp_tdata[132:116] <= 17'h10000))
   `SVG_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind sphere_vertex_generator_unit svg_checker u_svg_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
